@@ src/emsm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the encoder mode switch monitor.
// Depends on nothing; the divider, the monitor and the testbench import it.
package emsm_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int RSUM_W       = 16 + SLOT_W;
   localparam int BSUM_W       = 20 + SLOT_W;
   localparam int DSUM_W       = 16 + SLOT_W;

   // Shared divider geometry.
   localparam int DIV_W      = 42;
   localparam int DVSR_W     = 32;
   localparam int DCNT_W     = $clog2(DIV_W + 1);
   localparam int RATE_DIV_W = 28;
   localparam int BW_DIV_W   = 40;

   // 256 * 1e6 for the Q8.8 frame rate.
   localparam logic [RATE_DIV_W-1:0] RATE_NUMERATOR = 28'd256000000;
   // bytes * 1e6 / 4096 == bytes * 15625 / 64.
   localparam logic [13:0] BW_SCALE = 14'd15625;

   localparam logic [2:0] CSR_TARGET_RATE    = 3'd0;
   localparam logic [2:0] CSR_WINDOW_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_HIGH_BW_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_LOW_BW_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_ENCODE_LIMIT   = 3'd4;
   localparam logic [2:0] CSR_CODEC_STREAK   = 3'd5;
   localparam logic [2:0] CSR_RECT_STREAK    = 3'd6;

   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] byte_count;
      logic [25:0] changed_pixels;
      logic [25:0] frame_pixels;
      logic [23:0] encode_time;
      logic [31:0] frame_interval;
   } req_data_type;

   typedef struct packed {
      logic [15:0] avg_rate;
      logic [19:0] avg_bandwidth;
      logic [15:0] avg_dirty;
      logic [23:0] last_encode_time;
      logic        go_full_codec;
      logic        go_dirty_rects;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] rate;
      logic [19:0] bandwidth;
      logic [15:0] dirty;
   } win_entry_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
      logic [DCNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ src/emsm_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module emsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/emsm_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, dividend left-aligned by the caller.
// Depends on emsm_pkg.
module emsm_divider
   import emsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      fits    = trial >= {1'b0, dvsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvsr_in = div_req.divisor;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ src/encoder_mode_switch_monitor.sv @@
`timescale 1ns / 1ps
// Encoder mode switch monitor: frame statistics window and codec switch flags.
// A frame report runs up to six serial divisions on the shared one-bit-per-cycle divider,
// skipping those it does not need, then the update, streak and output states; the output
// state waits while an earlier result is still held, and the input is free again in the same
// cycle that the result appears. A streak clear goes straight to the output state. One
// request is in flight at a time. Reset is synchronous: configuration registers return to
// defaults, the window is empty and the streaks are zero.
module encoder_mode_switch_monitor
   import emsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   // The sequencer walks the divisions in order and skips those a request
   // does not need (first frame or no interval, no total pixels, empty window).
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_RATE   = 10'b0000000010,
      ST_BW     = 10'b0000000100,
      ST_DIRTY  = 10'b0000001000,
      ST_UPDATE = 10'b0000010000,
      ST_MRATE  = 10'b0000100000,
      ST_MBW    = 10'b0001000000,
      ST_MDIRTY = 10'b0010000000,
      ST_STREAK = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [7:0]  target_rate_ff, target_rate_in;
   logic [6:0]  window_length_ff, window_length_in;
   logic [11:0] high_bw_limit_ff, high_bw_limit_in;
   logic [11:0] low_bw_limit_ff, low_bw_limit_in;
   logic [23:0] encode_limit_ff, encode_limit_in;
   logic [7:0]  codec_needed_ff, codec_needed_in;
   logic [7:0]  rect_needed_ff, rect_needed_in;

   // Window bookkeeping.
   logic [WINDOW_DEPTH-1:0] entry_valid_ff, entry_valid_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [RSUM_W-1:0]       rate_sum_ff, rate_sum_in;
   logic [BSUM_W-1:0]       bw_sum_ff, bw_sum_in;
   logic [DSUM_W-1:0]       dirty_sum_ff, dirty_sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic [15:0] rate_mean_ff, rate_mean_in;
   logic [19:0] bw_mean_ff, bw_mean_in;
   logic [15:0] dirty_mean_ff, dirty_mean_in;
   logic [23:0] etime_held_ff, etime_held_in;
   logic        seen_frame_ff, seen_frame_in;
   logic [7:0]  high_streak_ff, high_streak_in;
   logic [7:0]  low_streak_ff, low_streak_in;
   logic [7:0]  low_rate_streak_ff, low_rate_streak_in;
   logic [7:0]  good_rate_streak_ff, good_rate_streak_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic launched_ff, launched_in;

   // Per-request payload.
   req_data_type        in_ff, in_in;
   logic [15:0]         r_ff, r_in;
   logic [19:0]         b_ff, b_in;
   logic [15:0]         d_ff, d_in;
   logic                entry_new_ff, entry_new_in;
   logic [BW_DIV_W-1:0] bw_num_ff, bw_num_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;

   logic [45:0]   bw_prod;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   win_entry_type old_entry;
   win_entry_type new_entry;
   logic          ram_wr_en;
   logic          accept;
   logic          timed;
   logic          in_div;
   logic          full_flag;
   logic          rects_flag;
   logic          rate_good;
   logic          rate_low;

   function automatic logic [7:0] bump(input logic [7:0] s);
      return (s == 8'hFF) ? s : s + 8'd1;
   endfunction

   emsm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   emsm_ram #(
      .WIDTH ($bits(win_entry_type)),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (new_entry),
      .rd_addr (slot_ff),
      .rd_data (old_entry)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign timed     = seen_frame_ff && (req_data.frame_interval != 32'd0);
   assign bw_prod   = 46'(req_data.byte_count) * 46'(BW_SCALE);
   assign in_div    = (state_ff == ST_RATE) || (state_ff == ST_BW) || (state_ff == ST_DIRTY) ||
                      (state_ff == ST_MRATE) || (state_ff == ST_MBW) ||
                      (state_ff == ST_MDIRTY);

   assign new_entry.rate      = r_ff;
   assign new_entry.bandwidth = b_ff;
   assign new_entry.dirty     = d_ff;
   assign ram_wr_en           = (state_ff == ST_UPDATE);

   // Rate checks against the target, taken on the current mean.
   assign rate_low  = (20'(rate_mean_ff) * 20'd5) < (20'(target_rate_ff) * 20'd1024);
   assign rate_good = (22'(rate_mean_ff) * 22'd20) >= (22'(target_rate_ff) * 22'd4864);

   assign full_flag = (high_streak_ff >= codec_needed_ff) ||
                      (low_rate_streak_ff >= codec_needed_ff) ||
                      (bw_mean_ff > {high_bw_limit_ff, 8'd0}) ||
                      ((20'(dirty_mean_ff) * 20'd10) > 20'd589824);

   assign rects_flag = (low_streak_ff >= rect_needed_ff) &&
                       ((target_rate_ff == 8'd0) || rate_good) &&
                       (bw_mean_ff <= {low_bw_limit_ff, 8'd0}) &&
                       (etime_held_ff <= encode_limit_ff);

   // Operand selection for the shared divider.
   always_comb begin
      div_req.start    = in_div && !launched_ff;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      div_req.steps    = '0;
      case (state_ff)
         ST_RATE: begin
            div_req.dividend = {RATE_NUMERATOR, (DIV_W - RATE_DIV_W)'(0)};
            div_req.divisor  = in_ff.frame_interval;
            div_req.steps    = DCNT_W'(RATE_DIV_W);
         end
         ST_BW: begin
            div_req.dividend = DIV_W'(bw_num_ff) << (DIV_W - BW_DIV_W);
            div_req.divisor  = in_ff.frame_interval;
            div_req.steps    = DCNT_W'(BW_DIV_W);
         end
         ST_DIRTY: begin
            div_req.dividend = DIV_W'({in_ff.changed_pixels, 16'd0});
            div_req.divisor  = DVSR_W'(in_ff.frame_pixels);
            div_req.steps    = DCNT_W'(DIV_W);
         end
         ST_MRATE: begin
            div_req.dividend = DIV_W'(rate_sum_ff) << (DIV_W - RSUM_W);
            div_req.divisor  = DVSR_W'(count_ff);
            div_req.steps    = DCNT_W'(RSUM_W);
         end
         ST_MBW: begin
            div_req.dividend = DIV_W'(bw_sum_ff) << (DIV_W - BSUM_W);
            div_req.divisor  = DVSR_W'(count_ff);
            div_req.steps    = DCNT_W'(BSUM_W);
         end
         ST_MDIRTY: begin
            div_req.dividend = DIV_W'(dirty_sum_ff) << (DIV_W - DSUM_W);
            div_req.divisor  = DVSR_W'(count_ff);
            div_req.steps    = DCNT_W'(DSUM_W);
         end
         default: begin
         end
      endcase
   end

   // Sequencer and state update.
   always_comb begin
      int slots;
      int next_slot;
      logic [RSUM_W-1:0] rs;
      logic [BSUM_W-1:0] bs;
      logic [DSUM_W-1:0] ds;
      logic [CNT_W-1:0]  cn;
      logic              ev;

      state_in            = state_ff;
      target_rate_in      = target_rate_ff;
      window_length_in    = window_length_ff;
      high_bw_limit_in    = high_bw_limit_ff;
      low_bw_limit_in     = low_bw_limit_ff;
      encode_limit_in     = encode_limit_ff;
      codec_needed_in     = codec_needed_ff;
      rect_needed_in      = rect_needed_ff;
      entry_valid_in      = entry_valid_ff;
      slot_in             = slot_ff;
      rate_sum_in         = rate_sum_ff;
      bw_sum_in           = bw_sum_ff;
      dirty_sum_in        = dirty_sum_ff;
      count_in            = count_ff;
      rate_mean_in        = rate_mean_ff;
      bw_mean_in          = bw_mean_ff;
      dirty_mean_in       = dirty_mean_ff;
      etime_held_in       = etime_held_ff;
      seen_frame_in       = seen_frame_ff;
      high_streak_in      = high_streak_ff;
      low_streak_in       = low_streak_ff;
      low_rate_streak_in  = low_rate_streak_ff;
      good_rate_streak_in = good_rate_streak_ff;
      rsp_valid_in        = rsp_valid_ff;
      launched_in         = in_div && !div_rsp.done;
      in_in               = in_ff;
      r_in                = r_ff;
      b_in                = b_ff;
      d_in                = d_ff;
      entry_new_in        = entry_new_ff;
      bw_num_in           = bw_num_ff;
      rsp_data_in         = rsp_data_ff;

      slots = int'(window_length_ff);
      if (slots == 0) begin
         slots = 1;
      end
      if (slots > WINDOW_DEPTH) begin
         slots = WINDOW_DEPTH;
      end
      next_slot = int'(slot_ff) + 1;
      if (next_slot >= slots) begin
         next_slot = 0;
      end

      ev = entry_valid_ff[slot_ff];
      rs = rate_sum_ff - (ev ? RSUM_W'(old_entry.rate) : RSUM_W'(0))
         + (entry_new_ff ? RSUM_W'(r_ff) : RSUM_W'(0));
      bs = bw_sum_ff - (ev ? BSUM_W'(old_entry.bandwidth) : BSUM_W'(0))
         + (entry_new_ff ? BSUM_W'(b_ff) : BSUM_W'(0));
      ds = dirty_sum_ff - (ev ? DSUM_W'(old_entry.dirty) : DSUM_W'(0))
         + (entry_new_ff ? DSUM_W'(d_ff) : DSUM_W'(0));
      cn = count_ff - (ev ? CNT_W'(1) : CNT_W'(0))
         + (entry_new_ff ? CNT_W'(1) : CNT_W'(0));

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes must arrive only while the block is idle; the block does not enforce this.
      if (csr_write_en) begin
         case (csr_index)
            CSR_TARGET_RATE:   target_rate_in = csr_wdata[7:0];
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_wdata[6:0];
               entry_valid_in   = '0;
               slot_in          = '0;
               rate_sum_in      = '0;
               bw_sum_in        = '0;
               dirty_sum_in     = '0;
               count_in         = '0;
            end
            CSR_HIGH_BW_LIMIT: high_bw_limit_in = csr_wdata[11:0];
            CSR_LOW_BW_LIMIT:  low_bw_limit_in  = csr_wdata[11:0];
            CSR_ENCODE_LIMIT:  encode_limit_in  = csr_wdata;
            CSR_CODEC_STREAK:  codec_needed_in  = csr_wdata[7:0];
            CSR_RECT_STREAK:   rect_needed_in   = csr_wdata[7:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_in        = req_data;
               bw_num_in    = bw_prod[45:6];
               r_in         = {target_rate_ff, 8'd0};
               b_in         = '0;
               d_in         = '0;
               entry_new_in = timed || (target_rate_ff != 8'd0);
               if (req_data.func == FUNC_CLEAR) begin
                  high_streak_in      = '0;
                  low_streak_in       = '0;
                  low_rate_streak_in  = '0;
                  good_rate_streak_in = '0;
                  state_in            = ST_OUT;
               end else if (timed) begin
                  state_in = ST_RATE;
               end else if (req_data.frame_pixels != 26'd0) begin
                  state_in = ST_DIRTY;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_RATE: begin
            if (div_rsp.done) begin
               r_in     = (|div_rsp.quotient[DIV_W-1:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
               state_in = ST_BW;
            end
         end
         ST_BW: begin
            if (div_rsp.done) begin
               b_in = (|div_rsp.quotient[DIV_W-1:20]) ? 20'hFFFFF : div_rsp.quotient[19:0];
               state_in = (in_ff.frame_pixels != 26'd0) ? ST_DIRTY : ST_UPDATE;
            end
         end
         ST_DIRTY: begin
            if (div_rsp.done) begin
               d_in     = (|div_rsp.quotient[DIV_W-1:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Retire the old slot, add the new frame and advance the ring pointer.
            rate_sum_in             = rs;
            bw_sum_in               = bs;
            dirty_sum_in            = ds;
            count_in                = cn;
            entry_valid_in[slot_ff] = entry_new_ff;
            slot_in                 = SLOT_W'(next_slot);
            etime_held_in           = in_ff.encode_time;
            seen_frame_in           = 1'b1;
            state_in                = (cn != CNT_W'(0)) ? ST_MRATE : ST_STREAK;
         end
         ST_MRATE: begin
            if (div_rsp.done) begin
               rate_mean_in = div_rsp.quotient[15:0];
               state_in     = ST_MBW;
            end
         end
         ST_MBW: begin
            if (div_rsp.done) begin
               bw_mean_in = div_rsp.quotient[19:0];
               state_in   = ST_MDIRTY;
            end
         end
         ST_MDIRTY: begin
            if (div_rsp.done) begin
               dirty_mean_in = div_rsp.quotient[15:0];
               state_in      = ST_STREAK;
            end
         end
         ST_STREAK: begin
            // Change level comes from the exact ratio of dirty to total pixels.
            if ({in_ff.changed_pixels, 1'b0} > 27'(in_ff.frame_pixels)) begin
               high_streak_in = bump(high_streak_ff);
               low_streak_in  = '0;
            end else if ((29'(in_ff.changed_pixels) * 29'd5) < 29'(in_ff.frame_pixels)) begin
               low_streak_in  = bump(low_streak_ff);
               high_streak_in = '0;
            end else begin
               high_streak_in = '0;
               low_streak_in  = '0;
            end
            // Rate level is judged on the new window mean.
            if (target_rate_ff != 8'd0) begin
               if (rate_low) begin
                  low_rate_streak_in  = bump(low_rate_streak_ff);
                  good_rate_streak_in = '0;
               end else if (rate_good) begin
                  good_rate_streak_in = bump(good_rate_streak_ff);
                  low_rate_streak_in  = '0;
               end else begin
                  low_rate_streak_in  = '0;
                  good_rate_streak_in = '0;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The result register frees up as soon as the previous result is taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.avg_rate         = rate_mean_ff;
               rsp_data_in.avg_bandwidth    = bw_mean_ff;
               rsp_data_in.avg_dirty        = dirty_mean_ff;
               rsp_data_in.last_encode_time = etime_held_ff;
               rsp_data_in.go_full_codec    = full_flag;
               rsp_data_in.go_dirty_rects   = rects_flag;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         target_rate_ff      <= 8'd60;
         window_length_ff    <= 7'd60;
         high_bw_limit_ff    <= 12'd100;
         low_bw_limit_ff     <= 12'd50;
         encode_limit_ff     <= 24'd16000;
         codec_needed_ff     <= 8'd5;
         rect_needed_ff      <= 8'd10;
         entry_valid_ff      <= '0;
         slot_ff             <= '0;
         rate_sum_ff         <= '0;
         bw_sum_ff           <= '0;
         dirty_sum_ff        <= '0;
         count_ff            <= '0;
         rate_mean_ff        <= '0;
         bw_mean_ff          <= '0;
         dirty_mean_ff       <= '0;
         etime_held_ff       <= '0;
         seen_frame_ff       <= 1'b0;
         high_streak_ff      <= '0;
         low_streak_ff       <= '0;
         low_rate_streak_ff  <= '0;
         good_rate_streak_ff <= '0;
         rsp_valid_ff        <= 1'b0;
         launched_ff         <= 1'b0;
      end else begin
         state_ff            <= state_in;
         target_rate_ff      <= target_rate_in;
         window_length_ff    <= window_length_in;
         high_bw_limit_ff    <= high_bw_limit_in;
         low_bw_limit_ff     <= low_bw_limit_in;
         encode_limit_ff     <= encode_limit_in;
         codec_needed_ff     <= codec_needed_in;
         rect_needed_ff      <= rect_needed_in;
         entry_valid_ff      <= entry_valid_in;
         slot_ff             <= slot_in;
         rate_sum_ff         <= rate_sum_in;
         bw_sum_ff           <= bw_sum_in;
         dirty_sum_ff        <= dirty_sum_in;
         count_ff            <= count_in;
         rate_mean_ff        <= rate_mean_in;
         bw_mean_ff          <= bw_mean_in;
         dirty_mean_ff       <= dirty_mean_in;
         etime_held_ff       <= etime_held_in;
         seen_frame_ff       <= seen_frame_in;
         high_streak_ff      <= high_streak_in;
         low_streak_ff       <= low_streak_in;
         low_rate_streak_ff  <= low_rate_streak_in;
         good_rate_streak_ff <= good_rate_streak_in;
         rsp_valid_ff        <= rsp_valid_in;
         launched_ff         <= launched_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff        <= in_in;
      r_ff         <= r_in;
      b_ff         <= b_in;
      d_ff         <= d_in;
      entry_new_ff <= entry_new_in;
      bw_num_ff    <= bw_num_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ verif/encoder_mode_switch_monitor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the encoder mode switch monitor.
// Depends on emsm_pkg and encoder_mode_switch_monitor; it predicts every response itself.
module encoder_mode_switch_monitor_tb;
   import emsm_pkg::*;

   localparam int SETTLE_CYCLES = 260;
   localparam int REQ_W         = $bits(req_data_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_write_en = 1'b0;
   logic [2:0]   csr_index = CSR_TARGET_RATE;
   logic [23:0]  csr_wdata = '0;

   encoder_mode_switch_monitor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the monitor state, kept in step with every accepted request.
   logic [15:0] rate_slot [WINDOW_DEPTH];
   logic [19:0] bw_slot [WINDOW_DEPTH];
   logic [15:0] dirty_slot [WINDOW_DEPTH];
   logic        slot_used [WINDOW_DEPTH];
   int unsigned next_slot, used_count;
   longint unsigned rate_total, bw_total, dirty_total;
   logic [15:0] mean_rate, mean_dirty;
   logic [19:0] mean_bw;
   logic [23:0] held_etime;
   logic        had_frame;
   int unsigned hi_change, lo_change, lo_rate, ok_rate;

   // Register shadows.
   logic [7:0]  fps_goal;
   logic [6:0]  win_len;
   logic [11:0] hi_bw_limit, lo_bw_limit;
   logic [23:0] etime_limit;
   logic [7:0]  codec_need, rect_need;

   rsp_data_type expected_rsps[$];
   int unsigned  error_count = 0;
   bit           stall_enable = 1'b1;

   function automatic int unsigned streak_up(int unsigned s);
      return (s < 255) ? s + 1 : 255;
   endfunction

   function automatic void empty_window();
      for (int i = 0; i < WINDOW_DEPTH; i++) slot_used[i] = 1'b0;
      next_slot = 0;
      used_count = 0;
      rate_total = 0;
      bw_total = 0;
      dirty_total = 0;
   endfunction

   function automatic void reset_shadow();
      empty_window();
      mean_rate = '0; mean_bw = '0; mean_dirty = '0;
      held_etime = '0; had_frame = 1'b0;
      hi_change = 0; lo_change = 0; lo_rate = 0; ok_rate = 0;
      fps_goal = 8'd60; win_len = 7'd60; hi_bw_limit = 12'd100; lo_bw_limit = 12'd50;
      etime_limit = 24'd16000; codec_need = 8'd5; rect_need = 8'd10;
   endfunction

   // Folds one frame report into the shadow window and streaks.
   function automatic void fold_frame(req_data_type r);
      longint unsigned fr, fb, fd, t, span, m;
      bit counts;
      int unsigned s;
      t = r.frame_interval;
      if (had_frame && t != 0) begin
         fr = 64'd256000000 / t;
         if (fr > 65535) fr = 65535;
         fb = (longint'(r.byte_count) * 64'd1000000) / (t * 64'd4096);
         if (fb > 1048575) fb = 1048575;
         counts = 1'b1;
      end else begin
         fr = longint'(fps_goal) << 8;
         fb = 0;
         counts = (fps_goal != 0);
      end
      if (r.frame_pixels != 0) begin
         fd = (longint'(r.changed_pixels) << 16) / r.frame_pixels;
         if (fd > 65535) fd = 65535;
      end else begin
         fd = 0;
      end
      s = next_slot;
      if (slot_used[s]) begin
         rate_total -= rate_slot[s];
         bw_total -= bw_slot[s];
         dirty_total -= dirty_slot[s];
         used_count--;
      end
      rate_slot[s] = 16'(fr); bw_slot[s] = 20'(fb); dirty_slot[s] = 16'(fd);
      slot_used[s] = counts;
      if (counts) begin
         rate_total += fr; bw_total += fb; dirty_total += fd;
         used_count++;
      end
      span = (win_len == 0) ? 1 : ((win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : win_len);
      s++;
      if (s >= span) s = 0;
      next_slot = s;
      if (used_count != 0) begin
         mean_rate = 16'(rate_total / used_count);
         mean_bw = 20'(bw_total / used_count);
         mean_dirty = 16'(dirty_total / used_count);
      end
      held_etime = r.encode_time;
      had_frame = 1'b1;
      if (2 * longint'(r.changed_pixels) > r.frame_pixels) begin
         hi_change = streak_up(hi_change); lo_change = 0;
      end else if (5 * longint'(r.changed_pixels) < r.frame_pixels) begin
         lo_change = streak_up(lo_change); hi_change = 0;
      end else begin
         hi_change = 0; lo_change = 0;
      end
      if (fps_goal != 0) begin
         m = mean_rate;
         if (5 * m < 1024 * longint'(fps_goal)) begin
            lo_rate = streak_up(lo_rate); ok_rate = 0;
         end else if (20 * m >= 4864 * longint'(fps_goal)) begin
            ok_rate = streak_up(ok_rate); lo_rate = 0;
         end else begin
            lo_rate = 0; ok_rate = 0;
         end
      end
   endfunction

   // Applies one request to the shadow state and returns the response it must produce.
   function automatic rsp_data_type predict_switch(req_data_type r);
      rsp_data_type o;
      if (r.func == FUNC_RECORD) begin
         fold_frame(r);
      end else begin
         hi_change = 0; lo_change = 0; lo_rate = 0; ok_rate = 0;
      end
      o.avg_rate = mean_rate;
      o.avg_bandwidth = mean_bw;
      o.avg_dirty = mean_dirty;
      o.last_encode_time = held_etime;
      o.go_full_codec = (hi_change >= codec_need) || (lo_rate >= codec_need) ||
                        (longint'(mean_bw) > 256 * longint'(hi_bw_limit)) ||
                        (10 * longint'(mean_dirty) > 589824);
      o.go_dirty_rects = (lo_change >= rect_need) &&
                         (fps_goal == 0 ||
                          20 * longint'(mean_rate) >= 4864 * longint'(fps_goal)) &&
                         (longint'(mean_bw) <= 256 * longint'(lo_bw_limit)) &&
                         (held_etime <= etime_limit);
      return o;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic int unsigned random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Sends one request and records its expected response when it is accepted.
   // The block is busy in the cycle after an acceptance, so the extra wait before each
   // request costs no back-to-back coverage.
   task automatic send_request(req_data_type r);
      repeat (random_gap() + 1) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(predict_switch(r));
      req_valid <= 1'b0;
   endtask

   // Waits for every outstanding response, then for the tail of any in-flight work.
   task automatic drain();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_TARGET_RATE:   fps_goal = val[7:0];
         CSR_WINDOW_LENGTH: begin
            win_len = val[6:0];
            empty_window();
         end
         CSR_HIGH_BW_LIMIT: hi_bw_limit = val[11:0];
         CSR_LOW_BW_LIMIT:  lo_bw_limit = val[11:0];
         CSR_ENCODE_LIMIT:  etime_limit = val;
         CSR_CODEC_STREAK:  codec_need = val[7:0];
         CSR_RECT_STREAK:   rect_need = val[7:0];
         default: ;
      endcase
   endtask

   function automatic req_data_type make_frame(logic [31:0] bytes, logic [25:0] dirty,
                                               logic [25:0] total, logic [23:0] etime,
                                               logic [31:0] interval);
      req_data_type r;
      r.func = FUNC_RECORD;
      r.byte_count = bytes;
      r.changed_pixels = dirty;
      r.frame_pixels = total;
      r.encode_time = etime;
      r.frame_interval = interval;
      return r;
   endfunction

   function automatic req_data_type make_clear();
      req_data_type r;
      r = req_data_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      r.func = FUNC_CLEAR;
      return r;
   endfunction

   // A frame, mostly realistic: intervals near a video period, modest byte counts and
   // screen sizes, each with rare outliers, and a change level from one of three bands.
   function automatic req_data_type random_frame(int unsigned change_band);
      logic [25:0] total;
      logic [25:0] dirty;
      logic [31:0] interval;
      total = ($urandom_range(0, 9) == 0) ? 26'($urandom) : 26'($urandom_range(1000, 2100000));
      case (change_band)
         0: dirty = total / 26'($urandom_range(6, 1000));
         1: dirty = total - total / 26'($urandom_range(3, 50));
         default: dirty = 26'(27'($urandom) % (27'(total) + 27'd1));
      endcase
      case ($urandom_range(0, 9))
         0: interval = $urandom;
         1: interval = 32'd0;
         2: interval = $urandom_range(1, 4000);
         default: interval = $urandom_range(8000, 60000);
      endcase
      return make_frame(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4000000),
                        dirty, total,
                        ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 30000)),
                        interval);
   endfunction

   // Response checker: every accepted response is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response, avg_rate", rsp_data.avg_rate, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.avg_rate !== want.avg_rate)
               report_mismatch("avg_rate", rsp_data.avg_rate, want.avg_rate);
            if (rsp_data.avg_bandwidth !== want.avg_bandwidth)
               report_mismatch("avg_bandwidth", rsp_data.avg_bandwidth, want.avg_bandwidth);
            if (rsp_data.avg_dirty !== want.avg_dirty)
               report_mismatch("avg_dirty", rsp_data.avg_dirty, want.avg_dirty);
            if (rsp_data.last_encode_time !== want.last_encode_time)
               report_mismatch("last_encode_time", rsp_data.last_encode_time,
                               want.last_encode_time);
            if (rsp_data.go_full_codec !== want.go_full_codec)
               report_mismatch("go_full_codec", rsp_data.go_full_codec, want.go_full_codec);
            if (rsp_data.go_dirty_rects !== want.go_dirty_rects)
               report_mismatch("go_dirty_rects", rsp_data.go_dirty_rects, want.go_dirty_rects);
         end
      end
   end

   // Receiver back-pressure: random stall stretches, mostly short, with stall-free spells.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_enable && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   // Directed corners: field extremes, both functions, first frame, zero interval,
   // zero total pixels and saturation of rate, bandwidth and dirty fraction.
   task automatic test_directed();
      send_request(make_frame(32'hFFFF_FFFF, 26'h3FF_FFFF, 26'h3FF_FFFF, 24'hFF_FFFF, 32'd5));
      send_request(make_frame(32'hFFFF_FFFF, 26'h3FF_FFFF, 26'd1, 24'd0, 32'd1));
      send_request(make_frame(32'd0, 26'd0, 26'd0, 24'd0, 32'd0));
      send_request(make_frame(32'd1000, 26'd0, 26'd0, 24'd100, 32'hFFFF_FFFF));
      send_request(make_frame(32'hFFFF_FFFF, 26'd10, 26'd100, 24'd16000, 32'd3906));
      send_request(make_clear());
      send_request(make_frame(32'd500000, 26'd20, 26'd100, 24'd16001, 32'd16666));
      send_request(make_frame(32'd500000, 26'd50, 26'd100, 24'd16000, 32'd16666));
      send_request(make_frame(32'd500000, 26'd51, 26'd100, 24'd1, 32'd16666));
      send_request(make_frame(32'd0, 26'h3FF_FFFF, 26'd0, 24'd0, 32'd16666));
      send_request(make_frame(32'hAAAA_AAAA, 26'h155_5555, 26'h2AA_AAAA, 24'hAA_AAAA,
                              32'h5555_5555));
      send_request(make_frame(32'h5555_5555, 26'h2AA_AAAA, 26'h155_5555, 24'h55_5555,
                              32'hAAAA_AAAA));
      send_request(make_clear());
   endtask

   // Streak saturation: a long run of low-change frames at a steady rate, then one of high-change frames.
   task automatic test_streaks();
      for (int i = 0; i < 270; i++)
         send_request(make_frame(32'd1000, 26'd1, 26'd1000, 24'd100, 32'd16666));
      for (int i = 0; i < 265; i++)
         send_request(make_frame(32'd1000, 26'd900, 26'd1000, 24'd100, 32'd200000));
      send_request(make_clear());
   endtask

   // Random traffic under one register setting.
   task automatic test_random_phase(int unsigned count);
      int unsigned band;
      band = $urandom_range(0, 2);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) band = $urandom_range(0, 2);
         if ($urandom_range(0, 24) == 0) send_request(make_clear());
         else send_request(random_frame(band));
      end
   endtask

   task automatic test_registers();
      // Extremes first, then random settings.
      write_csr(CSR_TARGET_RATE, 24'd0);
      write_csr(CSR_WINDOW_LENGTH, 24'd1);
      write_csr(CSR_CODEC_STREAK, 24'd1);
      write_csr(CSR_RECT_STREAK, 24'd1);
      write_csr(CSR_HIGH_BW_LIMIT, 24'd0);
      write_csr(CSR_LOW_BW_LIMIT, 24'd0);
      write_csr(CSR_ENCODE_LIMIT, 24'd0);
      test_random_phase(120);
      write_csr(CSR_TARGET_RATE, 24'd255);
      write_csr(CSR_WINDOW_LENGTH, 24'd64);
      write_csr(CSR_CODEC_STREAK, 24'd255);
      write_csr(CSR_RECT_STREAK, 24'd255);
      write_csr(CSR_HIGH_BW_LIMIT, 24'd4095);
      write_csr(CSR_LOW_BW_LIMIT, 24'd4095);
      write_csr(CSR_ENCODE_LIMIT, 24'hFF_FFFF);
      test_random_phase(150);
      write_csr(CSR_WINDOW_LENGTH, 24'd127);
      write_csr(CSR_TARGET_RATE, 24'd60);
      test_random_phase(120);
      write_csr(CSR_WINDOW_LENGTH, 24'd0);
      test_random_phase(40);
      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_TARGET_RATE, $urandom_range(0, 6) == 0 ? 24'd0 : $urandom_range(1, 255));
         write_csr(CSR_WINDOW_LENGTH, $urandom_range(1, 64));
         write_csr(CSR_HIGH_BW_LIMIT, $urandom_range(0, 4095));
         write_csr(CSR_LOW_BW_LIMIT, $urandom_range(0, 4095));
         write_csr(CSR_ENCODE_LIMIT, $urandom_range(0, 40000));
         write_csr(CSR_CODEC_STREAK, $urandom_range(1, 12));
         write_csr(CSR_RECT_STREAK, $urandom_range(1, 20));
         if (p == 4) stall_enable = 1'b0;
         if (p == 6) stall_enable = 1'b1;
         test_random_phase(80);
      end
   endtask

   initial begin
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_streaks();
      test_random_phase(200);
      test_registers();
      drain();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog sized for about 1800 requests at worst-case latency and stalls.
   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
src/emsm_pkg.sv
src/emsm_ram.sv
src/emsm_divider.sv
src/encoder_mode_switch_monitor.sv
verif/encoder_mode_switch_monitor_tb.sv
